/* rtl/mvm_pkg.sv */
// Shared types and constants for the matrix-vector multiply block.
// No dependencies; imported by mvm_mac and matrix_vector_multiply.
`default_nettype none

package mvm_pkg;

  localparam int unsigned VecLen  = 1024;
  localparam int unsigned VecAw   = $clog2(VecLen);
  localparam int unsigned CntW    = VecAw + 1;
  localparam int unsigned ColsW   = 11;
  localparam int unsigned RowsW   = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    op_e                    op;
    logic signed [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [RowsW-1:0]       row_index;
    logic signed [AccW-1:0] row_result;
    logic                   saturated;
    logic                   last_row;
  } out_item_t;

  // Per-item control carried down the datapath.
  typedef struct packed {
    logic             is_load;
    logic             row_end;
    logic [RowsW-1:0] row_index;
    logic             last_row;
  } mvm_ctl_t;

endpackage

`default_nettype wire

/* rtl/mvm_mac.sv */
// Multiply stage, saturating 64-bit accumulator and output register.
// Depends on mvm_pkg.
`default_nettype none

module mvm_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          s1_valid_i,
  input  mvm_pkg::mvm_ctl_t             s1_ctl_i,
  input  logic signed [mvm_pkg::ValW-1:0] s1_value_i,
  input  logic signed [mvm_pkg::ValW-1:0] s1_xv_i,
  output logic                          out_valid_o,
  output mvm_pkg::out_item_t            out_item_o
);
  import mvm_pkg::*;

  logic                   s2_valid_q, s2_valid_d;
  mvm_ctl_t               s2_ctl_q;
  logic signed [AccW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   clip_q, clip_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [AccW-1:0] sum;
  logic            ovf;
  logic signed [AccW-1:0] sat_sum;

  assign s2_valid_d = adv_i ? s1_valid_i : s2_valid_q;

  // Saturating add: overflow when operand signs agree and the sum's differs.
  always_comb begin
    sum = acc_q + prod_q;
    ovf = (acc_q[AccW-1] == prod_q[AccW-1]) && (sum[AccW-1] != acc_q[AccW-1]);
    if (ovf) begin
      sat_sum = acc_q[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat_sum = sum;
    end
  end

  always_comb begin
    acc_d       = acc_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (adv_i) begin
      out_valid_d = 1'b0;
      if (s2_valid_q) begin
        if (s2_ctl_q.is_load) begin
          acc_d  = '0;
          clip_d = 1'b0;
        end else if (s2_ctl_q.row_end) begin
          out_valid_d           = 1'b1;
          out_item_d.row_index  = s2_ctl_q.row_index;
          out_item_d.row_result = sat_sum;
          out_item_d.saturated  = clip_q | ovf;
          out_item_d.last_row   = s2_ctl_q.last_row;
          acc_d                 = '0;
          clip_d                = 1'b0;
        end else begin
          acc_d  = sat_sum;
          clip_d = clip_q | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_ctl_q <= s1_ctl_i;
      prod_q   <= s1_value_i * s1_xv_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* rtl/matrix_vector_multiply.sv */
// Top level of the matrix-vector multiply y = A*x (Q16.16 in, Q32.32 out).
// Depends on mvm_pkg and mvm_mac.
`default_nettype none

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (op, value)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (row result)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item is accepted per cycle while in_stall_o is low. A row result reaches
// the output register once its last matrix element has passed the vector
// store read, multiply, then saturating accumulate. The single-port-per-cycle
// vector store (one write or one read per item) and the one-MAC-per-item
// datapath set the rate. Reset clears the counters, accumulator and output
// valid; the vector store is not cleared and holds undefined data until
// loaded. While the output register holds an item and out_stall_i is high,
// the whole pipe freezes and in_stall_o is raised.

module matrix_vector_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mvm_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mvm_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [mvm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mvm_pkg::CfgDatW-1:0]   cfg_wdata_i
);
  import mvm_pkg::*;

  // Configuration
  logic [ColsW-1:0] num_cols_q;
  logic [RowsW-1:0] num_rows_q;

  // Control state
  logic [VecAw-1:0] load_idx_q, load_idx_d;
  logic [VecAw-1:0] col_q, col_d;
  logic [RowsW-1:0] row_q, row_d;

  // Vector store
  logic signed [ValW-1:0] vec_mem [VecLen];
  logic signed [ValW-1:0] xv_q;

  // Stage 1
  logic                   s1_valid_q;
  mvm_ctl_t               s1_ctl_q, s1_ctl_d;
  logic signed [ValW-1:0] s1_value_q;

  logic             adv;
  logic             acc_in;
  logic             acc_load;
  logic             acc_mat;
  logic [CntW-1:0]  n_eff;
  logic [CntW-1:0]  load_inc;
  logic [CntW-1:0]  col_inc;
  logic             row_end;
  logic             is_last;

  // Pipe moves unless a finished item sits stalled in the output register.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign acc_in     = in_valid_i && adv;
  assign acc_load   = acc_in && (in_item_i.op == OP_LOAD);
  assign acc_mat    = acc_in && (in_item_i.op == OP_MATRIX);

  // Effective column count, limited to 1..VecLen.
  always_comb begin
    if (num_cols_q == '0) begin
      n_eff = CntW'(1);
    end else if (CntW'(num_cols_q) > CntW'(VecLen)) begin
      n_eff = CntW'(VecLen);
    end else begin
      n_eff = CntW'(num_cols_q);
    end
  end

  assign load_inc = {1'b0, load_idx_q} + CntW'(1);
  assign col_inc  = {1'b0, col_q} + CntW'(1);
  // A shrunk column count mid-row ends the row on the next element.
  assign row_end  = (col_inc >= n_eff);
  assign is_last  = (row_q == (num_rows_q - RowsW'(1)));

  always_comb begin
    load_idx_d = load_idx_q;
    col_d      = col_q;
    row_d      = row_q;
    s1_ctl_d   = '0;
    if (acc_load) begin
      load_idx_d       = (load_inc >= n_eff) ? '0 : load_inc[VecAw-1:0];
      col_d            = '0;
      row_d            = '0;
      s1_ctl_d.is_load = 1'b1;
    end else if (acc_mat) begin
      s1_ctl_d.row_end   = row_end;
      s1_ctl_d.row_index = row_q;
      s1_ctl_d.last_row  = is_last;
      if (row_end) begin
        col_d = '0;
        row_d = is_last ? '0 : row_q + RowsW'(1);
      end else begin
        col_d = col_inc[VecAw-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= ColsW'(VecLen);
      num_rows_q <= RowsW'(1);
      load_idx_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_COLS: num_cols_q <= cfg_wdata_i[ColsW-1:0];
          REG_NUM_ROWS: num_rows_q <= cfg_wdata_i[RowsW-1:0];
          default: ;
        endcase
      end
      load_idx_q <= load_idx_d;
      col_q      <= col_d;
      row_q      <= row_d;
      if (adv) begin
        s1_valid_q <= acc_in;
      end
    end
  end

  // Store: loads write, matrix items read; one access per item, so a read never
  // shares a cycle with a write.
  always_ff @(posedge clk_i) begin
    if (acc_load) begin
      vec_mem[load_idx_q] <= in_item_i.value;
    end
    if (acc_mat) begin
      xv_q <= vec_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q   <= s1_ctl_d;
      s1_value_q <= in_item_i.value;
    end
  end

  mvm_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s1_valid_i (s1_valid_q),
    .s1_ctl_i   (s1_ctl_q),
    .s1_value_i (s1_value_q),
    .s1_xv_i    (xv_q),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

  // Stall only comes from a blocked output register.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output item");

  // A load restarts the matrix walk.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> (col_q == '0) && (row_q == '0))
    else $error("load did not clear row and column counters");

  // The row flagged last wraps the row counter.
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_mat && row_end && is_last) |=> (row_q == '0))
    else $error("row counter did not wrap after last row");

endmodule

`default_nettype wire
